FILE: rtl/jcp_pkg.sv
// Shared types and constants for the joint command parser with zone check.
// Used by jcp_zone and joint_command_parser_zone_check; no dependencies.
package jcp_pkg;

  // Line buffer depth default and field widths
  localparam int LINE_DEPTH_DEF = 32;
  localparam int CFG_W          = 9;
  localparam int DEG_W          = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int ACC_W          = 15;

  // Characters and limits
  localparam logic [7:0]       TERMINATOR = 8'd59;
  localparam logic [7:0]       CHAR_C     = 8'd67;
  localparam logic [7:0]       CHAR_0     = 8'd48;
  localparam logic [7:0]       CHAR_9     = 8'd57;
  localparam logic [DEG_W-1:0] DEG_MAX    = 14'd9999;
  localparam logic [ACC_W-1:0] FULL_TURN  = 15'd360;
  localparam int               MOD_STEPS  = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_J2_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_J3_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_J2_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_J2_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_J3_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_J3_HIGH  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIGIT,
    S_DIR0,
    S_DIR1,
    S_ZONE,
    S_PUT
  } parse_state_t;

  typedef enum logic [1:0] {
    Z_IDLE,
    Z_LOAD,
    Z_REDUCE,
    Z_CHECK
  } zone_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] j2_angle;
    logic [CFG_W-1:0] j3_angle;
    logic [CFG_W-1:0] j2_low;
    logic [CFG_W-1:0] j2_high;
    logic [CFG_W-1:0] j3_low;
    logic [CFG_W-1:0] j3_high;
  } jcp_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DEG_W-1:0] deg2;
    logic [DEG_W-1:0] deg3;
    logic             ccw2;
    logic             ccw3;
  } zone_ctl_t;

  typedef struct packed {
    logic done;
    logic ok;
  } zone_stat_t;

endpackage

FILE: rtl/jcp_zone.sv
// Forbidden zone checker: six points, one at a time, with a shift-subtract mod 360 unit.
// Depends on jcp_pkg.
module jcp_zone (
  input  logic              clk,
  input  logic              rst,
  input  jcp_pkg::jcp_cfg_t cfg,
  input  jcp_pkg::zone_ctl_t ctl,
  output jcp_pkg::zone_stat_t stat
);
  import jcp_pkg::*;

  zone_state_t      zstate;
  zone_state_t      zstate_next;
  logic             joint;
  logic [1:0]       part_idx;
  logic [2:0]       step;
  logic [ACC_W-1:0] acc;
  logic             neg;
  logic             ok;

  logic [DEG_W-1:0] deg_sel;
  logic [DEG_W-1:0] part;
  logic [CFG_W-1:0] angle;
  logic [CFG_W-1:0] low;
  logic [CFG_W-1:0] high;
  logic             adds;
  logic [ACC_W:0]   diff;
  logic [ACC_W:0]   diff_fix;
  logic [ACC_W-1:0] sub;
  logic             bad;
  logic             last;

  // Select the joint and the point under test
  always_comb begin
    deg_sel = joint ? ctl.deg3 : ctl.deg2;
    angle   = joint ? cfg.j3_angle : cfg.j2_angle;
    low     = joint ? cfg.j3_low : cfg.j2_low;
    high    = joint ? cfg.j3_high : cfg.j2_high;
    adds    = joint ? !ctl.ccw3 : ctl.ccw2;
    case (part_idx)
      2'd0:    part = deg_sel >> 2;
      2'd1:    part = deg_sel >> 1;
      default: part = deg_sel;
    endcase
    diff     = (ACC_W+1)'(angle) - (ACC_W+1)'(part);
    diff_fix = diff[ACC_W] ? diff + (ACC_W+1)'(FULL_TURN) : diff;
    sub      = FULL_TURN << step;
    bad      = !neg && (acc > ACC_W'(low)) && (acc < ACC_W'(high));
    last     = joint && (part_idx == 2'd2);
  end

  // Next state and status
  always_comb begin
    zstate_next = zstate;
    stat.done   = 1'b0;
    stat.ok     = ok && !bad;
    case (zstate)
      Z_IDLE: begin
        if (ctl.start) zstate_next = Z_LOAD;
      end
      Z_LOAD: begin
        zstate_next = adds ? Z_REDUCE : Z_CHECK;
      end
      Z_REDUCE: begin
        if (step == 3'd0) zstate_next = Z_CHECK;
      end
      Z_CHECK: begin
        if (last) begin
          stat.done   = 1'b1;
          zstate_next = Z_IDLE;
        end else begin
          zstate_next = Z_LOAD;
        end
      end
      default: zstate_next = Z_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zstate <= Z_IDLE;
    end else begin
      zstate <= zstate_next;
    end
  end

  // Point datapath: load, reduce, check
  always_ff @(posedge clk) begin
    case (zstate)
      Z_IDLE: begin
        joint    <= 1'b0;
        part_idx <= 2'd0;
        ok       <= 1'b1;
      end
      Z_LOAD: begin
        if (adds) begin
          acc  <= ACC_W'(angle) + ACC_W'(part);
          neg  <= 1'b0;
          step <= 3'(MOD_STEPS - 1);
        end else begin
          acc  <= diff_fix[ACC_W-1:0];
          neg  <= diff_fix[ACC_W];
        end
      end
      Z_REDUCE: begin
        if (acc >= sub) acc <= acc - sub;
        step <= step - 3'd1;
      end
      Z_CHECK: begin
        if (bad) ok <= 1'b0;
        if (part_idx == 2'd2) begin
          joint    <= 1'b1;
          part_idx <= 2'd0;
        end else begin
          part_idx <= part_idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/joint_command_parser_zone_check.sv
// Joint command parser: an accepted ';' starts the parse through the digit, direction,
// zone and put states to its result; other bytes go to the line buffer.
// Throughput: one byte a cycle while collecting; one command at a time while parsing,
// paced by the single line buffer read port and the one-point-at-a-time zone unit.
// Reset (rst, synchronous) clears state, config, out_valid, fill count and drop flag;
// the buffer is not cleared, positions at or past the fill count read as zero.
module joint_command_parser_zone_check #(
  parameter int LINE_DEPTH = jcp_pkg::LINE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [jcp_pkg::DEG_W-1:0]      deg_one,
  output logic [jcp_pkg::DEG_W-1:0]      deg_two,
  output logic [jcp_pkg::DEG_W-1:0]      deg_three,
  output logic                           ccw_one,
  output logic                           ccw_two,
  output logic                           ccw_three,
  output logic                           path_ok,
  output logic                           overflowed,
  input  logic                           cfg_write,
  input  logic [jcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jcp_pkg::CFG_W-1:0]      cfg_data
);
  import jcp_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = $clog2(LINE_DEPTH + 1);

  logic [7:0]       line_mem [LINE_DEPTH];
  logic [7:0]       rdata;
  logic             rzero;
  logic [PW-1:0]    rd_addr;

  parse_state_t     state;
  parse_state_t     state_next;
  logic [PW-1:0]    fill;
  logic             drop_seen;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    s;
  logic [1:0]       w;
  logic [1:0]       w_now;
  logic [1:0]       seg;
  logic [DEG_W-1:0] deg;
  logic [DEG_W-1:0] deg_calc;
  logic [16:0]      deg_wide;
  logic             cc0;
  logic [DEG_W-1:0] deg_seg [3];
  logic             ccw_seg [3];
  logic             zone_ok;

  logic [7:0]       cur_byte;
  logic             is_digit;
  logic             in_acc;
  logic             is_term;
  logic             out_free;

  jcp_cfg_t   cfg;
  zone_ctl_t  zone_ctl;
  zone_stat_t zone_stat;

  assign in_acc   = in_valid && !in_stall;
  assign is_term  = (rx_byte == TERMINATOR);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Configuration registers; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_J2_ANGLE: cfg.j2_angle <= cfg_data;
        CFG_J3_ANGLE: cfg.j3_angle <= cfg_data;
        CFG_J2_LOW:   cfg.j2_low   <= cfg_data;
        CFG_J2_HIGH:  cfg.j2_high  <= cfg_data;
        CFG_J3_LOW:   cfg.j3_low   <= cfg_data;
        CFG_J3_HIGH:  cfg.j3_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line buffer: write on a stored byte, registered read with a past-fill mark
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && !is_term && fill < PW'(LINE_DEPTH)) begin
      line_mem[fill[AW-1:0]] <= rx_byte;
    end
    rdata <= line_mem[rd_addr[AW-1:0]];
    rzero <= (rd_addr >= fill);
  end

  // Decode the byte just read and extend the rotation by one digit
  always_comb begin
    cur_byte = rzero ? 8'd0 : rdata;
    is_digit = (cur_byte >= CHAR_0) && (cur_byte <= CHAR_9);
    deg_wide = 17'({deg, 3'b000}) + 17'({deg, 1'b0}) + 17'(cur_byte - CHAR_0);
    deg_calc = (deg_wide > 17'(DEG_MAX)) ? DEG_MAX : deg_wide[DEG_W-1:0];
    w_now    = (deg < DEG_W'(10)) ? 2'd1 : ((deg < DEG_W'(100)) ? 2'd2 : 2'd3);
  end

  // Next state, read address and zone unit controls
  always_comb begin
    state_next    = state;
    rd_addr       = pos;
    zone_ctl.start = 1'b0;
    zone_ctl.deg2  = deg_seg[1];
    zone_ctl.deg3  = deg_seg[2];
    zone_ctl.ccw2  = ccw_seg[1];
    zone_ctl.ccw3  = ccw_seg[2];
    case (state)
      S_IDLE: begin
        rd_addr = PW'(2);
        if (in_acc && is_term) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (is_digit) begin
          rd_addr = pos + PW'(1);
        end else begin
          rd_addr    = s + PW'(2) + PW'(w_now);
          state_next = S_DIR0;
        end
      end
      S_DIR0: begin
        rd_addr    = s + PW'(3) + PW'(w);
        state_next = S_DIR1;
      end
      S_DIR1: begin
        rd_addr = s + PW'(6) + PW'(w);
        if (seg == 2'd2) begin
          zone_ctl.start = 1'b1;
          state_next     = S_ZONE;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_ZONE: begin
        if (zone_stat.done) state_next = S_PUT;
      end
      S_PUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count and drop flag; clear both once the result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      drop_seen <= 1'b0;
    end else if (state == S_IDLE && in_acc && !is_term) begin
      if (fill < PW'(LINE_DEPTH)) fill <= fill + PW'(1);
      else drop_seen <= 1'b1;
    end else if (state == S_PUT && out_free) begin
      fill      <= '0;
      drop_seen <= 1'b0;
    end
  end

  // Segment walk: digits, then the two direction bytes
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        s   <= '0;
        pos <= PW'(2);
        deg <= '0;
        seg <= 2'd0;
      end
      S_DIGIT: begin
        if (is_digit) begin
          deg <= deg_calc;
          pos <= pos + PW'(1);
        end else begin
          w <= w_now;
        end
      end
      S_DIR0: begin
        cc0 <= (cur_byte == CHAR_C);
      end
      S_DIR1: begin
        deg_seg[seg] <= deg;
        ccw_seg[seg] <= cc0 && (cur_byte == CHAR_C);
        s            <= s + PW'(4) + PW'(w);
        pos          <= s + PW'(6) + PW'(w);
        deg          <= '0;
        seg          <= seg + 2'd1;
      end
      S_ZONE: begin
        if (zone_stat.done) zone_ok <= zone_stat.ok;
      end
      default: ;
    endcase
  end

  jcp_zone u_zone (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ctl  (zone_ctl),
    .stat (zone_stat)
  );

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      deg_one    <= deg_seg[0];
      deg_two    <= deg_seg[1];
      deg_three  <= deg_seg[2];
      ccw_one    <= ccw_seg[0];
      ccw_two    <= ccw_seg[1];
      ccw_three  <= ccw_seg[2];
      path_ok    <= zone_ok;
      overflowed <= drop_seen;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PW'(LINE_DEPTH))
    else $error("fill count past line depth");

  a_clear_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (fill == '0) && !drop_seen)
    else $error("line not cleared with result");

  a_zone_done_state: assert property (@(posedge clk) disable iff (rst)
    zone_stat.done |-> state == S_ZONE)
    else $error("zone check finished outside zone wait");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIGIT |-> pos <= PW'(LINE_DEPTH))
    else $error("digit scan past line end");

  a_zone_start: assert property (@(posedge clk) disable iff (rst)
    zone_ctl.start |=> state == S_ZONE)
    else $error("zone start without zone wait");
`endif

endmodule
